// ===== rtl/core/crs_pkg.sv =====
// Shared types, constants and sizing helpers for the rectangle subtract block.
`default_nettype none

package crs_pkg;

    localparam int SIZE_BITS      = 14;
    localparam int COORD_BITS_DEF = 15;
    localparam int KIND_BITS      = 3;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE   = 3'd0,
        KIND_WHOLE  = 3'd1,
        KIND_TOP    = 3'd2,
        KIND_BOTTOM = 3'd3,
        KIND_LEFT   = 3'd4,
        KIND_RIGHT  = 3'd5
    } zone_kind_t;

    typedef struct packed {
        logic none;
        logic whole;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } zone_mask_t;

    // Zone payload: five rectangle coordinates of coord_bits+1 bits and seven sizes.
    function automatic int body_bits(input int coord_bits);
        return 5 * (coord_bits + 1) + 7 * SIZE_BITS;
    endfunction

    function automatic int desc_bits(input int coord_bits);
        return $bits(zone_mask_t) + body_bits(coord_bits);
    endfunction

    // Signed width that holds an edge plus a size without wrapping.
    function automatic int edge_bits(input int coord_bits);
        return ((coord_bits > SIZE_BITS + 1) ? coord_bits : SIZE_BITS + 1) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crs_queue.sv =====
// Small flip-flop FIFO that decouples the classifier from the zone emitter.
`default_nettype none

module crs_queue
    import crs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crs_front.sv =====
// Front end: takes requests, forms edge sums, classifies zones and queues them.
`default_nettype none

module crs_front
    import crs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic signed [COORD_BITS-1:0]   rect_x,
    input  wire logic signed [COORD_BITS-1:0]   rect_y,
    input  wire logic        [SIZE_BITS-1:0]    rect_width,
    input  wire logic        [SIZE_BITS-1:0]    rect_height,
    input  wire logic signed [COORD_BITS-1:0]   cover_x,
    input  wire logic signed [COORD_BITS-1:0]   cover_y,
    input  wire logic        [SIZE_BITS-1:0]    cover_width,
    input  wire logic        [SIZE_BITS-1:0]    cover_height,
    output logic                                push,
    output logic [desc_bits(COORD_BITS)-1:0]    push_data,
    input  wire logic                           full
);

    localparam int EW = edge_bits(COORD_BITS);
    localparam int OW = COORD_BITS + 1;

    logic                  accept;
    logic                  s1_valid_reg, s1_valid_next;

    logic signed [EW-1:0]  x_reg, y_reg, cx_reg, cy_reg;
    logic signed [EW-1:0]  right_reg, bottom_reg, cright_reg, cbottom_reg;
    logic [SIZE_BITS-1:0]  w_reg, h_reg;
    logic signed [EW-1:0]  x_next, y_next, cx_next, cy_next;
    logic signed [EW-1:0]  right_next, bottom_next, cright_next, cbottom_next;
    logic signed [EW-1:0]  w_ext, h_ext, cw_ext, ch_ext;

    logic                  clear;
    zone_mask_t            mask;
    logic signed [EW-1:0]  side_y, side_bot;
    logic signed [EW-1:0]  top_h, bot_h, left_w, right_w, side_h;

    // stage 1: capture request and edge sums
    assign req_stall = s1_valid_reg && full;
    assign accept    = req_valid && !req_stall;
    assign push      = s1_valid_reg && !full;

    assign w_ext  = {{(EW - SIZE_BITS){1'b0}}, rect_width};
    assign h_ext  = {{(EW - SIZE_BITS){1'b0}}, rect_height};
    assign cw_ext = {{(EW - SIZE_BITS){1'b0}}, cover_width};
    assign ch_ext = {{(EW - SIZE_BITS){1'b0}}, cover_height};

    always_comb
    begin
        x_next        = EW'(rect_x);
        y_next        = EW'(rect_y);
        cx_next       = EW'(cover_x);
        cy_next       = EW'(cover_y);
        right_next    = x_next + w_ext;
        bottom_next   = y_next + h_ext;
        cright_next   = cx_next + cw_ext;
        cbottom_next  = cy_next + ch_ext;
        s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            w_reg       <= rect_width;
            h_reg       <= rect_height;
            right_reg   <= right_next;
            bottom_reg  <= bottom_next;
            cright_reg  <= cright_next;
            cbottom_reg <= cbottom_next;
        end
    end

    // stage 2: overlap test, zone selection and sizes
    always_comb
    begin
        clear = (x_reg >= cright_reg) || (y_reg >= cbottom_reg) ||
                (right_reg <= cx_reg) || (bottom_reg <= cy_reg);
        mask        = '0;
        mask.whole  = clear;
        mask.top    = !clear && (y_reg < cy_reg);
        mask.bottom = !clear && (bottom_reg > cbottom_reg);
        mask.left   = !clear && (x_reg < cx_reg);
        mask.right  = !clear && (right_reg > cright_reg);
        mask.none   = !clear && !(mask.top || mask.bottom || mask.left || mask.right);

        side_y   = (y_reg < cy_reg) ? cy_reg : y_reg;
        side_bot = (bottom_reg > cbottom_reg) ? cbottom_reg : bottom_reg;
        side_h   = side_bot - side_y;
        top_h    = cy_reg - y_reg;
        bot_h    = bottom_reg - cbottom_reg;
        left_w   = cx_reg - x_reg;
        right_w  = right_reg - cright_reg;
    end

    assign push_data = {mask,
                        x_reg[OW-1:0], y_reg[OW-1:0], cbottom_reg[OW-1:0],
                        side_y[OW-1:0], cright_reg[OW-1:0],
                        w_reg, h_reg, top_h[SIZE_BITS-1:0], bot_h[SIZE_BITS-1:0],
                        left_w[SIZE_BITS-1:0], right_w[SIZE_BITS-1:0],
                        side_h[SIZE_BITS-1:0]};

endmodule

`default_nettype wire

// ===== rtl/core/crs_back.sv =====
// Back end: pops classified requests and emits one zone per cycle while the zone port does not stall.
`default_nettype none

module crs_back
    import crs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    output logic                               pop,
    input  wire logic [desc_bits(COORD_BITS)-1:0] pop_data,
    input  wire logic                          empty,
    output logic                               zone_valid,
    input  wire logic                          zone_stall,
    output logic [KIND_BITS-1:0]               zone_kind,
    output logic signed [COORD_BITS:0]         out_x,
    output logic signed [COORD_BITS:0]         out_y,
    output logic [SIZE_BITS-1:0]               out_width,
    output logic [SIZE_BITS-1:0]               out_height,
    output logic                               last_zone
);

    localparam int OW = COORD_BITS + 1;
    localparam int BW = body_bits(COORD_BITS);

    zone_mask_t            pop_mask;
    logic [BW-1:0]         pop_body;

    logic                  cur_valid_reg, cur_valid_next;
    zone_mask_t            rem_reg, rem_next;
    logic [BW-1:0]         body_reg;

    logic [OW-1:0]         x_d, y_d, boty_d, sidey_d, rightx_d;
    logic [SIZE_BITS-1:0]  w_d, h_d, toph_d, both_d, leftw_d, rightw_d, sideh_d;

    logic                  load_out, done;
    zone_mask_t            sel, rem_after;
    zone_kind_t            kind_sel;
    logic [OW-1:0]         x_sel, y_sel;
    logic [SIZE_BITS-1:0]  w_sel, h_sel;

    logic                  zone_valid_reg, zone_valid_next;
    zone_kind_t            kind_reg;
    logic [OW-1:0]         x_reg, y_reg;
    logic [SIZE_BITS-1:0]  w_reg, h_reg;
    logic                  last_reg;

    assign {pop_mask, pop_body} = pop_data;
    assign {x_d, y_d, boty_d, sidey_d, rightx_d,
            w_d, h_d, toph_d, both_d, leftw_d, rightw_d, sideh_d} = body_reg;

    always_comb
    begin
        sel      = '0;
        kind_sel = KIND_NONE;
        x_sel    = '0;
        y_sel    = '0;
        w_sel    = '0;
        h_sel    = '0;
        priority if (rem_reg.whole)
        begin
            sel.whole = 1'b1;
            kind_sel  = KIND_WHOLE;
            x_sel     = x_d;
            y_sel     = y_d;
            w_sel     = w_d;
            h_sel     = h_d;
        end
        else if (rem_reg.top)
        begin
            sel.top  = 1'b1;
            kind_sel = KIND_TOP;
            x_sel    = x_d;
            y_sel    = y_d;
            w_sel    = w_d;
            h_sel    = toph_d;
        end
        else if (rem_reg.bottom)
        begin
            sel.bottom = 1'b1;
            kind_sel   = KIND_BOTTOM;
            x_sel      = x_d;
            y_sel      = boty_d;
            w_sel      = w_d;
            h_sel      = both_d;
        end
        else if (rem_reg.left)
        begin
            sel.left = 1'b1;
            kind_sel = KIND_LEFT;
            x_sel    = x_d;
            y_sel    = sidey_d;
            w_sel    = leftw_d;
            h_sel    = sideh_d;
        end
        else if (rem_reg.right)
        begin
            sel.right = 1'b1;
            kind_sel  = KIND_RIGHT;
            x_sel     = rightx_d;
            y_sel     = sidey_d;
            w_sel     = rightw_d;
            h_sel     = sideh_d;
        end
        else
        begin
            // fully covered: zero-sized zone
            sel.none = 1'b1;
        end

        rem_after = rem_reg & ~sel;
        load_out  = cur_valid_reg && (!zone_valid_reg || !zone_stall);
        done      = load_out && (rem_after == '0);
        pop       = (!cur_valid_reg || done) && !empty;

        cur_valid_next = pop ? 1'b1 : (done ? 1'b0 : cur_valid_reg);
        rem_next       = pop ? pop_mask : (load_out ? rem_after : rem_reg);
        zone_valid_next = load_out ? 1'b1 : (zone_stall ? zone_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            rem_reg        <= '0;
            zone_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            rem_reg        <= rem_next;
            zone_valid_reg <= zone_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            body_reg <= pop_body;
        end
        if (load_out)
        begin
            kind_reg <= kind_sel;
            x_reg    <= x_sel;
            y_reg    <= y_sel;
            w_reg    <= w_sel;
            h_reg    <= h_sel;
            last_reg <= (rem_after == '0);
        end
    end

    assign zone_valid = zone_valid_reg;
    assign zone_kind  = kind_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_width  = w_reg;
    assign out_height = h_reg;
    assign last_zone  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/clip_rectangle_subtract.sv =====
// Top level of the rectangle subtract block: classifier, queue and zone emitter.
//
//   channel   valid        stall        payload
//   request   req_valid    req_stall    rect_*, cover_*
//   zone      zone_valid   zone_stall   zone_kind, out_*, last_zone
//
// A request can be taken every cycle while the queue is not full; it yields one to four zones,
// one per cycle while the zone port does not stall, so the zone port sets the sustained request rate.
// The first zone passes the edge sum registers, classify, the queue, pop and the output registers before it is valid.
// Reset clears all valid and queue state.
// A stalled zone port backs up the queue and then stalls the request port.
`default_nettype none

module clip_rectangle_subtract
    import crs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic signed [COORD_BITS-1:0] rect_x,
    input  wire logic signed [COORD_BITS-1:0] rect_y,
    input  wire logic        [SIZE_BITS-1:0]  rect_width,
    input  wire logic        [SIZE_BITS-1:0]  rect_height,
    input  wire logic signed [COORD_BITS-1:0] cover_x,
    input  wire logic signed [COORD_BITS-1:0] cover_y,
    input  wire logic        [SIZE_BITS-1:0]  cover_width,
    input  wire logic        [SIZE_BITS-1:0]  cover_height,
    output logic                              zone_valid,
    input  wire logic                         zone_stall,
    output logic [KIND_BITS-1:0]              zone_kind,
    output logic signed [COORD_BITS:0]        out_x,
    output logic signed [COORD_BITS:0]        out_y,
    output logic [SIZE_BITS-1:0]              out_width,
    output logic [SIZE_BITS-1:0]              out_height,
    output logic                              last_zone
);

    localparam int QW = desc_bits(COORD_BITS);

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_push_data, q_pop_data;

    crs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .cover_x      (cover_x),
        .cover_y      (cover_y),
        .cover_width  (cover_width),
        .cover_height (cover_height),
        .push         (q_push),
        .push_data    (q_push_data),
        .full         (q_full)
    );

    crs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    crs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (q_pop),
        .pop_data   (q_pop_data),
        .empty      (q_empty),
        .zone_valid (zone_valid),
        .zone_stall (zone_stall),
        .zone_kind  (zone_kind),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_width  (out_width),
        .out_height (out_height),
        .last_zone  (last_zone)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for clip_rectangle_subtract: directed table plus random requests checked by a predictor.
`timescale 1ns / 1ps

module testbench;
    import crs_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;
    localparam int RANDOM_REQUESTS = 140;

    typedef struct {
        logic signed [CB-1:0]    rect_x;
        logic signed [CB-1:0]    rect_y;
        logic [SIZE_BITS-1:0]    rect_width;
        logic [SIZE_BITS-1:0]    rect_height;
        logic signed [CB-1:0]    cover_x;
        logic signed [CB-1:0]    cover_y;
        logic [SIZE_BITS-1:0]    cover_width;
        logic [SIZE_BITS-1:0]    cover_height;
    } rect_req_t;

    typedef struct {
        zone_kind_t              kind;
        logic signed [CB:0]      out_x;
        logic signed [CB:0]      out_y;
        logic [SIZE_BITS-1:0]    out_width;
        logic [SIZE_BITS-1:0]    out_height;
        logic                    last_zone;
    } zone_t;

    typedef struct {
        int         rect_x;
        int         rect_y;
        int         rect_width;
        int         rect_height;
        int         cover_x;
        int         cover_y;
        int         cover_width;
        int         cover_height;
        bit         typed;
        zone_kind_t kind;
        int         ex;
        int         ey;
        int         ew;
        int         eh;
    } dir_row_t;

    // typed rows: disjoint, fully covered, extremes; the rest go through the predictor
    dir_row_t directed_rows [21] = '{
        '{0, 0, 10, 10, 10, 0, 5, 5, 1'b1, KIND_WHOLE, 0, 0, 10, 10},
        '{0, 0, 10, 10, 0, 10, 5, 5, 1'b1, KIND_WHOLE, 0, 0, 10, 10},
        '{0, 0, 10, 10, -20, 0, 20, 10, 1'b1, KIND_WHOLE, 0, 0, 10, 10},
        '{5, 5, 10, 10, 5, 5, 10, 10, 1'b1, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 4, 4, -100, -100, 16383, 16383, 1'b1, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 20, 20, 5, 5, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, 0, 5, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, 0, -5, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, 5, 0, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, -5, 0, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{5, 5, 0, 10, 0, 0, 20, 20, 1'b1, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, 5, 5, 0, 0, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{16383, 16383, 16383, 16383, -16384, -16384, 0, 0,
          1'b1, KIND_WHOLE, 16383, 16383, 16383, 16383},
        '{-16384, -16384, 16383, 16383, 16383, 16383, 16383, 16383,
          1'b1, KIND_WHOLE, -16384, -16384, 16383, 16383},
        '{16000, 16000, 16383, 16383, 16300, 16300, 100, 100, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{-16384, -16384, 100, 100, -16384, -16384, 16383, 16383,
          1'b1, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, KIND_WHOLE, 0, 0, 0, 0},
        '{-16384, -16384, 16383, 16383, -100, -100, 16383, 16383,
          1'b0, KIND_NONE, 0, 0, 0, 0},
        '{0, 0, 10, 10, 5, 5, 10, 10, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{-1, -1, 2, 2, -1, -1, 1, 1, 1'b0, KIND_NONE, 0, 0, 0, 0},
        '{10922, -10923, 10922, 5461, -10923, 10922, 5461, 10922,
          1'b0, KIND_NONE, 0, 0, 0, 0}
    };

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic signed [CB-1:0]    rect_x = '0;
    logic signed [CB-1:0]    rect_y = '0;
    logic [SIZE_BITS-1:0]    rect_width = '0;
    logic [SIZE_BITS-1:0]    rect_height = '0;
    logic signed [CB-1:0]    cover_x = '0;
    logic signed [CB-1:0]    cover_y = '0;
    logic [SIZE_BITS-1:0]    cover_width = '0;
    logic [SIZE_BITS-1:0]    cover_height = '0;
    logic                    zone_valid;
    logic                    zone_stall = 1'b0;
    logic [KIND_BITS-1:0]    zone_kind;
    logic signed [CB:0]      out_x;
    logic signed [CB:0]      out_y;
    logic [SIZE_BITS-1:0]    out_width;
    logic [SIZE_BITS-1:0]    out_height;
    logic                    last_zone;

    zone_t zones_due[$];
    int    send_idle_pct = 28;
    int    recv_idle_pct = 72;
    logic  long_hold = 1'b0;
    int    hold_count = 0;
    int    cycle_count = 0;
    int    mismatches = 0;
    int    requests_sent = 0;
    int    zones_checked = 0;
    int    kinds_seen [8];

    clip_rectangle_subtract #(.COORD_BITS(CB)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .cover_x      (cover_x),
        .cover_y      (cover_y),
        .cover_width  (cover_width),
        .cover_height (cover_height),
        .zone_valid   (zone_valid),
        .zone_stall   (zone_stall),
        .zone_kind    (zone_kind),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_width    (out_width),
        .out_height   (out_height),
        .last_zone    (last_zone)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic zone_t make_zone(input zone_kind_t k, input longint x, input longint y,
                                        input longint w, input longint h);
        zone_t z;
        z.kind       = k;
        z.out_x      = x[CB:0];
        z.out_y      = y[CB:0];
        z.out_width  = w[SIZE_BITS-1:0];
        z.out_height = h[SIZE_BITS-1:0];
        z.last_zone  = 1'b0;
        return z;
    endfunction

    // visible zones of a request, in emit order, appended to zones_due
    function automatic void predict_zones(input rect_req_t r);
        longint x, y, w, h, cx, cy, cw, ch;
        longint rgt, bot, crgt, cbot, side_y, side_h;
        zone_t  found[$];
        zone_t  z;
        x = r.rect_x;
        y = r.rect_y;
        w = r.rect_width;
        h = r.rect_height;
        cx = r.cover_x;
        cy = r.cover_y;
        cw = r.cover_width;
        ch = r.cover_height;
        rgt = x + w;
        bot = y + h;
        crgt = cx + cw;
        cbot = cy + ch;
        if (x >= crgt || y >= cbot || rgt <= cx || bot <= cy)
        begin
            found = {found, make_zone(KIND_WHOLE, x, y, w, h)};
        end
        else
        begin
            side_y = (y < cy) ? cy : y;
            side_h = ((bot > cbot) ? cbot : bot) - side_y;
            if (y < cy)
                found = {found, make_zone(KIND_TOP, x, y, w, cy - y)};
            if (bot > cbot)
                found = {found, make_zone(KIND_BOTTOM, x, cbot, w, bot - cbot)};
            if (x < cx)
                found = {found, make_zone(KIND_LEFT, x, side_y, cx - x, side_h)};
            if (rgt > crgt)
                found = {found, make_zone(KIND_RIGHT, crgt, side_y, rgt - crgt, side_h)};
            if (found.size() == 0)
                found = {found, make_zone(KIND_NONE, 0, 0, 0, 0)};
        end
        foreach (found[i])
        begin
            z = found[i];
            z.last_zone = (i == found.size() - 1);
            zones_due = {zones_due, z};
        end
    endfunction

    // mostly overlapping pairs of small size, some near the coordinate limits, some raw noise
    function automatic rect_req_t random_request();
        rect_req_t r;
        int sel, span, rx, ry, rw, rh, cw, ch, cxi, cyi;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            r.rect_x = CB'($urandom);
            r.rect_y = CB'($urandom);
            r.rect_width = SIZE_BITS'($urandom);
            r.rect_height = SIZE_BITS'($urandom);
            r.cover_x = CB'($urandom);
            r.cover_y = CB'($urandom);
            r.cover_width = SIZE_BITS'($urandom);
            r.cover_height = SIZE_BITS'($urandom);
            return r;
        end
        span = (sel < 30) ? 16383 : 64;
        if (sel < 22)
        begin
            rx = 16383 - $urandom_range(300);
            ry = 16383 - $urandom_range(300);
        end
        else if (sel < 30)
        begin
            rx = $urandom_range(300) - 16384;
            ry = $urandom_range(300) - 16384;
        end
        else
        begin
            rx = $urandom_range(32767) - 16384;
            ry = $urandom_range(32767) - 16384;
        end
        rw = $urandom_range(span);
        rh = $urandom_range(span);
        cw = $urandom_range(span);
        ch = $urandom_range(span);
        cxi = rx + $urandom_range(rw + cw + 20) - cw - 10;
        cyi = ry + $urandom_range(rh + ch + 20) - ch - 10;
        r.rect_x = rx[CB-1:0];
        r.rect_y = ry[CB-1:0];
        r.rect_width = rw[SIZE_BITS-1:0];
        r.rect_height = rh[SIZE_BITS-1:0];
        r.cover_x = cxi[CB-1:0];
        r.cover_y = cyi[CB-1:0];
        r.cover_width = cw[SIZE_BITS-1:0];
        r.cover_height = ch[SIZE_BITS-1:0];
        return r;
    endfunction

    task automatic send_request(input rect_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        rect_x <= r.rect_x;
        rect_y <= r.rect_y;
        rect_width <= r.rect_width;
        rect_height <= r.rect_height;
        cover_x <= r.cover_x;
        cover_y <= r.cover_y;
        cover_width <= r.cover_width;
        cover_height <= r.cover_height;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    always @(posedge clk)
    begin
        if (long_hold && hold_count < HOLD_CYCLES)
        begin
            zone_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            zone_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        zone_t want;
        if (rst_n && zone_valid && !zone_stall)
        begin
            kinds_seen[zone_kind]++;
            if (zones_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected zone: kind %0d x %0d y %0d w %0d h %0d last %0b",
                             zone_kind, out_x, out_y, out_width, out_height, last_zone);
            end
            else
            begin
                want = zones_due.pop_front();
                zones_checked++;
                if (zone_kind !== want.kind || out_x !== want.out_x || out_y !== want.out_y
                    || out_width !== want.out_width || out_height !== want.out_height
                    || last_zone !== want.last_zone)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("zone mismatch: expected kind %0d x %0d y %0d w %0d h %0d last %0b",
                                 want.kind, want.out_x, want.out_y, want.out_width,
                                 want.out_height, want.last_zone);
                        $display("               actual   kind %0d x %0d y %0d w %0d h %0d last %0b",
                                 zone_kind, out_x, out_y, out_width, out_height, last_zone);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d zones still due", cycle_count,
                     zones_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        rect_req_t req;
        zone_t     hand;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            req.rect_x = directed_rows[i].rect_x[CB-1:0];
            req.rect_y = directed_rows[i].rect_y[CB-1:0];
            req.rect_width = directed_rows[i].rect_width[SIZE_BITS-1:0];
            req.rect_height = directed_rows[i].rect_height[SIZE_BITS-1:0];
            req.cover_x = directed_rows[i].cover_x[CB-1:0];
            req.cover_y = directed_rows[i].cover_y[CB-1:0];
            req.cover_width = directed_rows[i].cover_width[SIZE_BITS-1:0];
            req.cover_height = directed_rows[i].cover_height[SIZE_BITS-1:0];
            send_request(req);
            if (directed_rows[i].typed)
            begin
                hand = make_zone(directed_rows[i].kind, directed_rows[i].ex, directed_rows[i].ey,
                                 directed_rows[i].ew, directed_rows[i].eh);
                hand.last_zone = 1'b1;
                zones_due = {zones_due, hand};
            end
            else
            begin
                predict_zones(req);
            end
        end
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 55)
            begin
                send_idle_pct = 72;
                recv_idle_pct <= 28;
            end
            if (n == 110)
            begin
                // no idling, but the zone port holds off long enough to back up the request port
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                long_hold <= 1'b1;
            end
            req = random_request();
            send_request(req);
            predict_zones(req);
        end
        req_valid <= 1'b0;
        while (zones_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d requests sent, %0d zones checked, %0d mismatches", requests_sent,
                 zones_checked, mismatches);
        $display("zones by kind: none %0d whole %0d top %0d bottom %0d left %0d right %0d",
                 kinds_seen[KIND_NONE], kinds_seen[KIND_WHOLE], kinds_seen[KIND_TOP],
                 kinds_seen[KIND_BOTTOM], kinds_seen[KIND_LEFT], kinds_seen[KIND_RIGHT]);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/crs_pkg.sv
rtl/core/crs_queue.sv
rtl/core/crs_front.sv
rtl/core/crs_back.sv
rtl/core/clip_rectangle_subtract.sv
test/testbench.sv
